FILE: design/coprime_pair_test_defines.svh
// Assertion macros shared by the coprime pair test RTL.
// Each macro expects clk and rst_n to exist in the using module.
`ifndef COPRIME_PAIR_TEST_DEFINES_SVH
`define COPRIME_PAIR_TEST_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition holds at every clock edge out of reset
`define CPT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent holds in the same cycle as the antecedent
`define CPT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent holds in the cycle after the antecedent
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPT_ASSERT_ALWAYS(label, cond, msg)
`define CPT_ASSERT_IMPLIES(label, ante, cons, msg)
`define CPT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/cpt_pkg.sv
// Package for the coprime pair test: width default, cell opcodes,
// controller states and the datapath status bundle. No dependencies.
package cpt_pkg;

    localparam int CPT_VALUE_WIDTH = 10;

    // Command broadcast to every bit cell each cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHIFT_A,
        OP_SHIFT_B,
        OP_SUB_A,
        OP_SUB_B
    } cpt_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } cpt_state_t;

    // Summary of the operand row seen by the controller
    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_one;
        logic b_one;
        logic a_odd;
        logic b_odd;
        logic a_ge_b;
    } cpt_status_t;

endpackage

FILE: design/coprime_pair_test.sv
// Top level of the coprime pair test: a row of bit cells holding both
// operands, driven by the cpt_ctrl sequencer.
// Depends on cpt_pkg, cpt_cell, cpt_ctrl and coprime_pair_test_defines.svh.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-------------------------------
//  request  | start / busy          | first_value, second_value
//  result   | done (1-cycle strobe) | is_coprime_flag
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result strobe. One binary GCD step (shift, or subtract and shift)
// runs per cycle across the cell row until an operand reaches zero, and the
// check that sees it raises done; a zero first operand or two even operands
// are settled by that check with no steps. The next request may be taken in
// the cycle done is shown. Reset is asynchronous, active low, and clears the
// sequencer; the result cannot be stalled by the receiver.
`include "coprime_pair_test_defines.svh"
module coprime_pair_test
    import cpt_pkg::*;
#(
    parameter int VALUE_WIDTH = CPT_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] first_value,
    input  logic [VALUE_WIDTH-1:0] second_value,
    output logic                   done,
    output logic                   is_coprime_flag
);

    cpt_op_t                op;
    cpt_status_t            status;
    logic [VALUE_WIDTH-1:0] a_bits;
    logic [VALUE_WIDTH-1:0] b_bits;
    logic [VALUE_WIDTH-1:0] dab_bits;
    logic [VALUE_WIDTH-1:0] dba_bits;
    logic [VALUE_WIDTH:0]   a_ext;
    logic [VALUE_WIDTH:0]   b_ext;
    logic [VALUE_WIDTH:0]   dab_ext;
    logic [VALUE_WIDTH:0]   dba_ext;
    logic [VALUE_WIDTH:0]   borrow_ab;
    logic [VALUE_WIDTH:0]   borrow_ba;
    logic [VALUE_WIDTH:0]   nz_a;
    logic [VALUE_WIDTH:0]   nz_b;

    // Zero fills in above the top cell on right shifts
    assign a_ext   = {1'b0, a_bits};
    assign b_ext   = {1'b0, b_bits};
    assign dab_ext = {1'b0, dab_bits};
    assign dba_ext = {1'b0, dba_bits};

    assign borrow_ab[0]          = 1'b0;
    assign borrow_ba[0]          = 1'b0;
    assign nz_a[VALUE_WIDTH]     = 1'b0;
    assign nz_b[VALUE_WIDTH]     = 1'b0;

    // Cell row, bit 0 at the bottom
    for (genvar i = 0; i < VALUE_WIDTH; i++)
    begin : g_cell
        cpt_cell u_cell (
            .clk           (clk),
            .op            (op),
            .load_a        (first_value[i]),
            .load_b        (second_value[i]),
            .a_up          (a_ext[i+1]),
            .b_up          (b_ext[i+1]),
            .dab_up        (dab_ext[i+1]),
            .dba_up        (dba_ext[i+1]),
            .borrow_ab_in  (borrow_ab[i]),
            .borrow_ba_in  (borrow_ba[i]),
            .a             (a_bits[i]),
            .b             (b_bits[i]),
            .dab           (dab_bits[i]),
            .dba           (dba_bits[i]),
            .borrow_ab_out (borrow_ab[i+1]),
            .borrow_ba_out (borrow_ba[i+1])
        );

        // Nonzero chains from the top down
        assign nz_a[i] = a_bits[i] | nz_a[i+1];
        assign nz_b[i] = b_bits[i] | nz_b[i+1];
    end

    // Status for the sequencer
    assign status.a_zero = ~nz_a[0];
    assign status.b_zero = ~nz_b[0];
    assign status.a_one  = a_bits[0] & ~nz_a[1];
    assign status.b_one  = b_bits[0] & ~nz_b[1];
    assign status.a_odd  = a_bits[0];
    assign status.b_odd  = b_bits[0];
    assign status.a_ge_b = ~borrow_ab[VALUE_WIDTH];

    cpt_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .first_value     (first_value),
        .second_value    (second_value),
        .status          (status),
        .op              (op),
        .busy            (busy),
        .done            (done),
        .is_coprime_flag (is_coprime_flag)
    );

    `CPT_ASSERT_IMPLIES(a_zero_b_ge, busy && status.b_zero, status.a_ge_b, "bad borrow, b zero")

endmodule

FILE: design/cpt_cell.sv
// One bit slice of the binary GCD datapath: holds bit i of both operands,
// ripples subtract borrows upward, takes shifted bits from the cell above.
// Depends on cpt_pkg.
module cpt_cell
    import cpt_pkg::*;
(
    input  logic    clk,
    input  cpt_op_t op,
    input  logic    load_a,
    input  logic    load_b,
    input  logic    a_up,
    input  logic    b_up,
    input  logic    dab_up,
    input  logic    dba_up,
    input  logic    borrow_ab_in,
    input  logic    borrow_ba_in,
    output logic    a,
    output logic    b,
    output logic    dab,
    output logic    dba,
    output logic    borrow_ab_out,
    output logic    borrow_ba_out
);

    logic a_reg, a_next;
    logic b_reg, b_next;

    assign a = a_reg;
    assign b = b_reg;

    // Full subtractor slices for a - b and b - a
    assign dab           = a_reg ^ b_reg ^ borrow_ab_in;
    assign borrow_ab_out = (~a_reg & b_reg) | (~(a_reg ^ b_reg) & borrow_ab_in);
    assign dba           = b_reg ^ a_reg ^ borrow_ba_in;
    assign borrow_ba_out = (~b_reg & a_reg) | (~(a_reg ^ b_reg) & borrow_ba_in);

    // Next bit per command; shifts pull from the neighbor above
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        case (op)
            OP_LOAD:
            begin
                a_next = load_a;
                b_next = load_b;
            end
            OP_SHIFT_A: a_next = a_up;
            OP_SHIFT_B: b_next = b_up;
            OP_SUB_A:   a_next = dab_up;
            OP_SUB_B:   b_next = dba_up;
            default:
            begin
                a_next = a_reg;
                b_next = b_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

endmodule

FILE: design/cpt_ctrl.sv
// Sequencer for the coprime pair test: takes requests, steers the cell row
// through binary GCD steps and raises the one-cycle result strobe.
// Depends on cpt_pkg and coprime_pair_test_defines.svh.
`include "coprime_pair_test_defines.svh"
module cpt_ctrl
    import cpt_pkg::*;
#(
    parameter int VALUE_WIDTH = CPT_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] first_value,
    input  logic [VALUE_WIDTH-1:0] second_value,
    input  cpt_status_t            status,
    output cpt_op_t                op,
    output logic                   busy,
    output logic                   done,
    output logic                   is_coprime_flag
);

    cpt_state_t state_reg, state_next;
    logic       done_reg, done_next;
    logic       flag_reg, flag_next;
    logic       early_reg, early_next;
    logic       finish;

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign is_coprime_flag = flag_reg;

    // Zero first operand or a common factor of two settles the answer at once
    assign early_next = (first_value == '0) || (!first_value[0] && !second_value[0]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_RUN;
            ST_RUN:  if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands and result
    always_comb
    begin
        op        = OP_HOLD;
        finish    = 1'b0;
        flag_next = flag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start) op = OP_LOAD;
            end
            ST_RUN:
            begin
                if (early_reg)
                begin
                    finish    = 1'b1;
                    flag_next = 1'b0;
                end
                else if (status.a_zero)
                begin
                    finish    = 1'b1;
                    flag_next = status.b_one;
                end
                else if (status.b_zero)
                begin
                    finish    = 1'b1;
                    flag_next = status.a_one;
                end
                else if (!status.a_odd)
                    op = OP_SHIFT_A;
                else if (!status.b_odd)
                    op = OP_SHIFT_B;
                else if (status.a_ge_b)
                    op = OP_SUB_A;
                else
                    op = OP_SUB_B;
            end
            default: op = OP_HOLD;
        endcase
    end

    assign done_next = finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            flag_reg  <= 1'b0;
            early_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            flag_reg  <= flag_next;
            if (start && (state_reg == ST_IDLE))
                early_reg <= early_next;
        end
    end

    `CPT_ASSERT_NEXT(a_accept_runs, start && !busy, busy && !done, "no run after accept")
    `CPT_ASSERT_NEXT(a_finish_strobes, busy && finish, done && !busy, "no strobe after finish")
    `CPT_ASSERT_NEXT(a_early_false, busy && early_reg, done && !is_coprime_flag, "early not false")

endmodule

FILE: bench/coprime_pair_test_test.sv
// Testbench for coprime_pair_test: random and directed operand pairs, each flag
// checked against an in-bench Euclid computation. Depends on cpt_pkg and the RTL.
module coprime_pair_test_test;
    import cpt_pkg::*;

    localparam int VALUE_WIDTH = CPT_VALUE_WIDTH;
    localparam int VALUE_MAX = (1 << VALUE_WIDTH) - 1;
    localparam int RANDOM_PAIRS = 750;
    // Drain time after the last result: worst GCD latency plus margin
    localparam int TAIL_CYCLES = 4 * VALUE_WIDTH + 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [VALUE_WIDTH-1:0] operand_t;

    // One pending request with its lead-in gap
    typedef struct {
        operand_t    first;
        operand_t    second;
        int unsigned gap;
        bit          drain;
    } pair_req_t;

    // One predicted result with its operands for reporting
    typedef struct {
        operand_t first;
        operand_t second;
        bit       flag;
    } coprime_pred_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    operand_t first_value = '0;
    operand_t second_value = '0;
    logic     busy;
    logic     done;
    logic     is_coprime_flag;

    pair_req_t     pair_q[$];
    coprime_pred_t coprime_q[$];
    int unsigned   gap_left = 0;
    bit            gap_loaded = 1'b0;
    bit            results_drained = 1'b1;
    int            error_count = 0;
    int unsigned   cycle_count = 0;

    coprime_pair_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .first_value(first_value),
        .second_value(second_value),
        .done(done),
        .is_coprime_flag(is_coprime_flag)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Expected flag: nonzero first operand and Euclid divisor of one
    function automatic bit coprime_of(input operand_t a, input operand_t b);
        operand_t x;
        operand_t y;
        operand_t last;
        if (a == '0)
            return 1'b0;
        x = a;
        y = b;
        last = a;
        while (x != '0)
        begin
            last = x;
            x = y % x;
            y = last;
        end
        return (last == operand_t'(1));
    endfunction

    task automatic queue_pair(input operand_t a, input operand_t b, input int unsigned gap,
                              input bit drain);
        pair_req_t r;
        r.first = a;
        r.second = b;
        r.gap = gap;
        r.drain = drain;
        pair_q.push_back(r);
    endtask

    // Drain flag sampled away from the active edge
    always @(negedge clk)
        results_drained = (coprime_q.size() == 0);

    // Request driver
    always @(posedge clk)
    begin
        bit keep;
        bit launch;
        coprime_pred_t p;
        keep = 1'b0;
        launch = 1'b0;
        if (rst_n)
        begin
            keep = start && busy;
            if (start && !busy)
            begin
                p.first = first_value;
                p.second = second_value;
                p.flag = coprime_of(first_value, second_value);
                coprime_q.push_back(p);
                gap_loaded = 1'b0;
            end
            if (!keep && pair_q.size() != 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left = pair_q[0].gap;
                    gap_loaded = 1'b1;
                end
                else if (gap_left != 0 && !busy)
                    gap_left--;
                if (gap_left == 0 && !(pair_q[0].drain && !results_drained))
                begin
                    first_value <= pair_q[0].first;
                    second_value <= pair_q[0].second;
                    void'(pair_q.pop_front());
                    gap_loaded = 1'b0;
                    launch = 1'b1;
                end
            end
        end
        start <= keep || launch;
    end

    // Result monitor
    always @(posedge clk)
    begin
        coprime_pred_t p;
        if (rst_n && done)
        begin
            if (coprime_q.size() == 0)
            begin
                $error("is_coprime_flag: result with no request pending, actual %0b",
                       is_coprime_flag);
                error_count++;
            end
            else
            begin
                p = coprime_q.pop_front();
                if (is_coprime_flag !== p.flag)
                begin
                    $error("is_coprime_flag (%0d, %0d): expected %0b, actual %0b",
                           p.first, p.second, p.flag, is_coprime_flag);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int i;
        int kind;
        int unsigned k;
        int unsigned gap;
        bit burst;
        operand_t a;
        operand_t b;

        // Directed: zero operands, ones, extremes, worst-case Euclid chains
        queue_pair(operand_t'(0), operand_t'(0), 0, 0);
        queue_pair(operand_t'(0), operand_t'(1), 1, 0);
        queue_pair(operand_t'(0), operand_t'(VALUE_MAX), 0, 0);
        queue_pair(operand_t'(1), operand_t'(0), 2, 0);
        queue_pair(operand_t'(2), operand_t'(0), 0, 0);
        queue_pair(operand_t'(VALUE_MAX), operand_t'(0), 3, 0);
        queue_pair(operand_t'(1), operand_t'(1), 0, 0);
        queue_pair(operand_t'(1), operand_t'(VALUE_MAX), 0, 0);
        queue_pair(operand_t'(VALUE_MAX), operand_t'(1), 1, 0);
        queue_pair(operand_t'(VALUE_MAX), operand_t'(VALUE_MAX), 0, 0);
        queue_pair(operand_t'(VALUE_MAX), operand_t'(VALUE_MAX - 1), 0, 0);
        queue_pair(operand_t'(VALUE_MAX - 1), operand_t'(VALUE_MAX), 2, 0);
        queue_pair(operand_t'(512), operand_t'(VALUE_MAX), 0, 0);
        queue_pair(operand_t'(512), operand_t'(512), 0, 0);
        queue_pair(operand_t'(512), operand_t'(256), 1, 0);
        queue_pair(operand_t'(1022), operand_t'(511), 0, 0);
        queue_pair(operand_t'(610), operand_t'(987), 0, 0);
        queue_pair(operand_t'(987), operand_t'(610), 3, 0);
        queue_pair(operand_t'(377), operand_t'(610), 0, 0);
        queue_pair(operand_t'(2), operand_t'(1), 0, 0);
        queue_pair(operand_t'(6), operand_t'(4), 0, 0);
        queue_pair(operand_t'(341), operand_t'(VALUE_MAX), 0, 0);
        queue_pair(operand_t'(682), operand_t'(341), 1, 1);

        // Random mix: uniform, small, shared factor, neighbors, zeros, extremes
        for (i = 0; i < RANDOM_PAIRS; i++)
        begin
            kind = $urandom_range(0, 9);
            a = operand_t'($urandom);
            b = operand_t'($urandom);
            case (kind)
                5:
                begin
                    a = operand_t'($urandom_range(0, 15));
                    b = operand_t'($urandom_range(0, 15));
                end
                6:
                begin
                    k = $urandom_range(2, 31);
                    a = operand_t'(k * $urandom_range(0, VALUE_MAX / k));
                    b = operand_t'(k * $urandom_range(0, VALUE_MAX / k));
                end
                7:
                    b = $urandom_range(0, 1) ? a + 1'b1 : a - 1'b1;
                8:
                begin
                    if ($urandom_range(0, 1))
                        a = operand_t'($urandom_range(0, 1));
                    else
                        b = operand_t'($urandom_range(0, 1));
                end
                9:
                begin
                    case ($urandom_range(0, 4))
                        0: a = '0;
                        1: a = operand_t'(1);
                        2: a = operand_t'(VALUE_MAX - 1);
                        3: a = operand_t'(VALUE_MAX);
                        default: a = operand_t'(1 << (VALUE_WIDTH - 1));
                    endcase
                end
                default:
                begin
                end
            endcase
            // Every third stretch of 60 requests runs back to back
            burst = ((i / 60) % 3) == 1;
            gap = burst ? 0 : $urandom_range(0, 3);
            queue_pair(a, b, gap, (i % 150) == 149);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pair_q.size() != 0 || start || coprime_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
